// ===== rtl/core/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
package modexp_pkg;

  localparam int unsigned ModulusReset = 23;

  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0
  } reg_idx_t;

endpackage

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_stall, in_base_value,      | in
//          | in_exponent                             |
//  result  | out_valid, out_stall, out_power_result  | out
//  config  | psel, penable, pwrite, paddr, pwdata... | in/out
//
// One beat is worked on at a time. The base is first reduced by a multiply by
// one, then each exponent bit costs up to two modular products, each worked
// bit by bit in the two-cell doubling/adding chain. Reset is synchronous and
// active low and sets the modulus to 23. A finished result is held in the output
// register while out_stall is high; the next input beat is accepted as soon as
// that register is free or leaving.
module modular_exponentiation_unit
  import modexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_base_value,
  input  logic [WIDTH-1:0] in_exponent,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_power_result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_SQR, S_NEXT} state_t;

  state_t           state_r;
  logic [WIDTH-1:0] mod_r, base_r, acc_r, exp_r, out_r;
  logic             out_valid_r;
  logic             mm_start;
  logic [WIDTH-1:0] mm_x, mm_y;
  logic             mm_done;
  logic [WIDTH-1:0] mm_prod;
  logic             accept, busy;
  logic             out_free;
  logic             out_load;
  logic             wr_en;
  logic [WIDTH-1:0] wdata_ext;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && (paddr[1:0] == 2'(REG_MODULUS));
  assign wdata_ext = WIDTH'(pwdata);
  assign prdata   = 32'(mod_r);

  assign busy     = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy || !out_free;
  assign accept   = in_valid && !in_stall;

  // A new result enters the output register at this edge.
  assign out_load = (accept && mod_r < WIDTH'(2)) ||
                    (state_r == S_NEXT && exp_r == '0 && out_free);

  assign out_valid        = out_valid_r;
  assign out_power_result = out_r;

  // Operand selection: reduction multiplies one by the base, so the base is
  // scanned bit by bit and every partial sum stays below the modulus.
  always_comb begin
    mm_x = base_r;
    mm_y = base_r;
    unique case (state_r)
      S_RED:   mm_x = WIDTH'(1);
      S_MUL:   mm_x = acc_r;
      default: mm_y = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= WIDTH'(ModulusReset);
    end else if (wr_en) begin
      mod_r <= wdata_ext;
    end
  end

  modexp_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .x_in(mm_x), .y_in(mm_y),
    .mod_in(mod_r), .done_r(mm_done), .prod_r(mm_prod)
  );

  logic issued_r;
  assign mm_start = (state_r == S_RED || state_r == S_MUL || state_r == S_SQR) && !issued_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;
      if (mm_start) issued_r <= 1'b1;
      unique case (state_r)
        S_IDLE: if (accept) begin
          base_r <= in_base_value;
          exp_r  <= in_exponent;
          acc_r  <= WIDTH'(1);
          if (mod_r < WIDTH'(2)) begin
            out_r       <= '0;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_RED;
          end
        end
        S_RED: if (mm_done) begin
          base_r   <= mm_prod;
          issued_r <= 1'b0;
          state_r  <= S_NEXT;
        end
        S_MUL: if (mm_done) begin
          acc_r    <= mm_prod;
          issued_r <= 1'b0;
          state_r  <= S_SQR;
        end
        S_SQR: if (mm_done) begin
          base_r   <= mm_prod;
          exp_r    <= exp_r >> 1;
          issued_r <= 1'b0;
          state_r  <= S_NEXT;
        end
        S_NEXT: begin
          if (exp_r == '0) begin
            if (out_free) begin
              out_r       <= acc_r;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else if (exp_r[0]) begin
            state_r <= S_MUL;
          end else begin
            state_r <= S_SQR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept) else $error("beat accepted while busy");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_result))
    else $error("stalled result changed");
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && mod_r >= WIDTH'(2) |-> out_power_result < mod_r)
    else $error("result not reduced");

endmodule

// ===== rtl/core/modexp_cell.sv =====
// One cell of the modular reduction chain: subtracts the modulus when it fits.
module modexp_cell
  import modexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic [WIDTH:0]   val_in,
  input  logic [WIDTH-1:0] mod_in,
  output logic [WIDTH-1:0] val_r
);

  logic [WIDTH-1:0] val_nxt;

  // The incoming value is below twice the modulus, so one subtraction reduces it.
  always_comb begin
    if (val_in >= {1'b0, mod_in}) begin
      val_nxt = WIDTH'(val_in - {1'b0, mod_in});
    end else begin
      val_nxt = val_in[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/core/modexp_mulmod.sv =====
// Bit-serial modular multiplier built from a doubling cell and an adding cell.
module modexp_mulmod
  import modexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x_in,
  input  logic [WIDTH-1:0] y_in,
  input  logic [WIDTH-1:0] mod_in,
  output logic             done_r,
  output logic [WIDTH-1:0] prod_r
);

  localparam int CW = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DBL, S_ADD} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] x_r, y_r;
  logic             done_nxt;
  logic [WIDTH-1:0] dbl_q, add_q;
  logic [WIDTH:0]   dbl_sum, add_sum;

  // The running product lives in the adding cell; the first step doubles zero.
  assign dbl_sum = (cnt_r == CW'(WIDTH)) ? '0 : ({1'b0, add_q} + {1'b0, add_q});
  assign add_sum = {1'b0, dbl_q} + (y_r[WIDTH-1] ? {1'b0, x_r} : '0);
  assign prod_r  = add_q;

  // Doubling cell feeds the adding cell; each step of the product runs through both cells in turn.
  modexp_cell #(.WIDTH(WIDTH)) u_dbl (.clk(clk), .val_in(dbl_sum), .mod_in(mod_in),
                                      .val_r(dbl_q));
  modexp_cell #(.WIDTH(WIDTH)) u_add (.clk(clk), .val_in(add_sum), .mod_in(mod_in),
                                      .val_r(add_q));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_DBL;
        cnt_nxt   = CW'(WIDTH);
      end
      S_DBL: state_nxt = S_ADD;
      S_ADD: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = S_DBL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      x_r <= x_in;
      y_r <= y_in;
    end else if (state_r == S_ADD) begin
      y_r <= {y_r[WIDTH-2:0], 1'b0};
    end
  end

endmodule

// ===== tb/modular_exponentiation_unit_checker.sv =====
// Checker for the modular exponentiation unit: tracks the modulus and scores results.
`timescale 1ns / 100ps
module modular_exponentiation_unit_checker
  import modexp_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [WIDTH-1:0] in_base_value,
  input  logic [WIDTH-1:0] in_exponent,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [WIDTH-1:0] out_power_result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               results_pending,
  output int               results_seen
);

  logic [WIDTH-1:0] modulus_copy;
  logic [WIDTH-1:0] power_queue[$];

  // Product mod m, formed in double width so nothing overflows.
  function automatic logic [WIDTH-1:0] times_mod(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                                 logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] wide;
    wide = a * b;
    wide = wide % m;
    return wide[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e,
                                                 logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] sq;
    if (m < 2) return '0;
    acc = 1;
    sq = b % m;
    for (int i = 0; i < WIDTH; i++) begin
      if (e[i]) acc = times_mod(acc, sq, m);
      sq = times_mod(sq, sq, m);
    end
    return acc;
  endfunction

  assign results_pending = power_queue.size();

  always @(posedge clk) begin
    logic [WIDTH-1:0] want;
    if (!rst_n) begin
      modulus_copy = WIDTH'(ModulusReset);
      fail_count   = 0;
      results_seen = 0;
      power_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'({REG_MODULUS, 2'b00}))
        modulus_copy = pwdata[WIDTH-1:0];
      if (in_valid && !in_stall)
        power_queue.push_back(power_mod(in_base_value, in_exponent, modulus_copy));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (power_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   out_power_result);
        end else begin
          want = power_queue.pop_front();
          if (out_power_result !== want) begin
            fail_count++;
            $display("%0t: power_result mismatch, expected %h, actual %h", $time, want,
                     out_power_result);
          end
        end
      end
    end
  end

endmodule

// ===== tb/modular_exponentiation_unit_tb.sv =====
// Testbench top for the modular exponentiation unit: stimulus and verdict.
`timescale 1ns / 100ps
module modular_exponentiation_unit_tb;
  import modexp_pkg::*;

  localparam int WIDTH = 32;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WIDTH-1:0] in_base_value = '0;
  logic [WIDTH-1:0] in_exponent = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WIDTH-1:0] out_power_result;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [1:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int results_pending;
  int results_seen;

  // Percentages of cycles in which each side holds off; changed as the run goes on.
  int sender_idle_pct = 29;
  int receiver_stall_pct = 76;
  int beats_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modular_exponentiation_unit #(.WIDTH(WIDTH)) dut (.*);

  modular_exponentiation_unit_checker #(.WIDTH(WIDTH)) checker_i (.*);

  // The receiver stalls at random, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Drive one input beat and hold it until the block takes it. The sender may
  // idle for some cycles first; valid is lowered only in those idle cycles.
  task automatic send_beat(logic [WIDTH-1:0] base_v, logic [WIDTH-1:0] exp_v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base_v;
    in_exponent   <= exp_v;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    // Idling moves through its three settings as the run proceeds.
    if (beats_sent == 95) begin
      sender_idle_pct    = 76;
      receiver_stall_pct = 29;
    end else if (beats_sent == 190) begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
    end
  endtask

  // Hold the sender off until every expected result has left the block.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write in two phases: setup, then access; pready is always high.
  task automatic write_modulus(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'({REG_MODULUS, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random exponent of random length, so item lengths vary but every bit is
  // exercised; the base is sometimes pinned near the modulus or the field ends.
  task automatic send_random(logic [31:0] modv);
    logic [WIDTH-1:0] base_v;
    logic [WIDTH-1:0] exp_v;
    int               len;
    len   = $urandom_range(WIDTH);
    exp_v = (len == 0) ? '0 : ($urandom() & ({WIDTH{1'b1}} >> (WIDTH - len)));
    case ($urandom_range(5))
      0: base_v = '1;
      1: base_v = modv - 1;
      2: base_v = $urandom_range(3);
      default: base_v = $urandom();
    endcase
    send_beat(base_v, exp_v);
  endtask

  logic [31:0] modulus_list[8];

  initial begin
    modulus_list = '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd65521,
                     32'd0, 32'd1, 32'd23, 32'd0};
    modulus_list[7] = $urandom() | 32'd3;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset modulus of 23: zero and unit exponents,
    // a base equal to the modulus, and the extremes of both fields.
    send_beat(32'd5, 32'd0);
    send_beat(32'd0, 32'd0);
    send_beat(32'hFFFF_FFFF, 32'd0);
    send_beat(32'd30, 32'd1);
    send_beat(32'd23, 32'd1);
    send_beat(32'hFFFF_FFFF, 32'd1);
    send_beat(32'd0, 32'd7);
    send_beat(32'd1, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'd5, 32'd22);
    send_beat(32'd22, 32'h8000_0000);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA);
    send_beat(32'd2, 32'd11);

    // The sender holds off here until the block has emptied.
    wait_until_drained();

    // Each phase sets a fresh modulus while idle, including the widest, the
    // smallest prime and the degenerate values zero and one.
    foreach (modulus_list[p]) begin
      write_modulus(modulus_list[p]);
      send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(modulus_list[p], 32'd1);
      for (int k = 0; k < 29; k++) send_random(modulus_list[p]);
      wait_until_drained();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d beats and %0d results over %0d modulus settings,", beats_sent,
             results_seen, 1 + $size(modulus_list));
    $display("with sender and receiver idling swapped and then switched off.");
    if (fail_count == 0) begin
      $display("modular_exponentiation_unit regression: pass");
    end else begin
      $display("modular_exponentiation_unit regression: fail");
    end
    $finish;
  end

  // Watchdog sized for the worst case of all 262 beats, several times over.
  initial begin
    #60_000_000;
    $display("modular_exponentiation_unit regression: fail");
    $finish;
  end

endmodule
